// ===== hdl/awe_pkg.sv =====
// Shared types, constants and coefficient tables for the A-weighted energy accumulator.
package awe_pkg;

  localparam int FRAC_SIG      = 24;
  localparam int FRAC_COEF     = 22;
  localparam int COEF_W        = 24;
  localparam int COEF_MAGW     = 23;
  localparam int MUL_HALF_W    = 24;
  localparam int MUL_MAGW      = 2 * MUL_HALF_W;
  localparam int MUL_PROD_W    = COEF_MAGW + MUL_HALF_W;
  localparam int SEC_W         = 3;
  localparam int CNT_W         = 20;
  localparam int ENERGY_W      = 64;
  localparam int SQ_IN_W       = 32;

  localparam int DIV_QW        = FRAC_SIG + 4;

  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(20000);
  localparam logic [CNT_W:0]   WIN_FULL  = (CNT_W + 1)'(1 << CNT_W);

  localparam logic signed [COEF_W-1:0] GAIN_Q22 = 24'sd1072656;
  localparam logic [MUL_MAGW-1:0] ROUND_HALF = MUL_MAGW'(1 << (FRAC_COEF - 1));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD_U,
    ST_G_LO,
    ST_G_HI,
    ST_G_LD,
    ST_Y,
    ST_A1_LO,
    ST_A1_HI,
    ST_A2_LO,
    ST_A2_HI,
    ST_D1,
    ST_SQ,
    ST_ACC
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MS_GAIN,
    MS_A1,
    MS_A2
  } mul_sel_t;

  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_LO,
    MOP_HI
  } mul_op_t;

  typedef struct packed {
    logic             div_start;
    logic             load_u_div;
    mul_sel_t         mul_sel;
    mul_op_t          mul_op;
    logic             load_u_mul;
    logic             calc_y;
    logic             upd_d0;
    logic             upd_d1;
    logic             advance;
    logic             square;
    logic             accumulate;
    logic [SEC_W-1:0] sec;
  } awe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_blocked;
  } awe_status_t;

  function automatic logic signed [COEF_W-1:0] a1_coef(input logic [SEC_W-1:0] s);
    case (s)
      3'd0:    return -24'sd589451;
      3'd1:    return -24'sd7905848;
      3'd2:    return -24'sd8364025;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] a2_coef(input logic [SEC_W-1:0] s);
    case (s)
      3'd0:    return 24'sd20710;
      3'd1:    return 24'sd3717921;
      3'd2:    return 24'sd4169757;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [2:0] b1_coef(input logic [SEC_W-1:0] s);
    case (s)
      3'd0:    return 3'sd2;
      3'd1:    return -3'sd2;
      3'd2:    return -3'sd2;
      default: return '0;
    endcase
  endfunction

  function automatic logic b2_coef(input logic [SEC_W-1:0] s);
    case (s)
      3'd0, 3'd1, 3'd2: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

endpackage

// ===== hdl/a_weighted_energy_accumulator_core.sv =====
// Top level of the A-weighted energy accumulator: sequencer plus datapath.
// The window result appears only on the sample that closes a window. A new sample is taken
//   only once the sequencer has returned to idle; the shared 23x24 multiplier takes two
//   passes per coefficient product, and an untaken result holds the final accumulate step.
// Reset (synchronous, rst_n low): window length 20000, filter delays, count and total cleared.
module a_weighted_energy_accumulator_core #(
  parameter int SECTIONS     = 3,
  parameter int SAMPLE_BITS  = 12,
  parameter int SIGNAL_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [19:0]            cfg_window_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_energy_sum,
  output logic                   out_sum_saturated
);
  import awe_pkg::*;

  awe_cmd_t    cmd;
  awe_status_t status;

  assign cfg_ready = 1'b1;

  awe_ctrl #(
    .SECTIONS(SECTIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  awe_datapath #(
    .SECTIONS     (SECTIONS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .SIGNAL_WIDTH (SIGNAL_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_adc_sample     (in_adc_sample),
    .cfg_valid         (cfg_valid),
    .cfg_window_length (cfg_window_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy_sum    (out_energy_sum),
    .out_sum_saturated (out_sum_saturated)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while a sample is still in work");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> !in_ready)
    else $error("divider finished while the sequencer is idle");

endmodule

// ===== hdl/awe_scale_div.sv =====
// Registered constant scaler that maps a raw sample by 1/(2^SAMPLE_BITS - 1) into Q4.24.
module awe_scale_div #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [SAMPLE_BITS-1:0]       sample,
  output logic                         done,
  output logic [awe_pkg::DIV_QW-1:0]   quot
);
  import awe_pkg::*;

  localparam int SB2 = 2 * SAMPLE_BITS;
  localparam int RSH = FRAC_SIG % SAMPLE_BITS;
  localparam logic [SAMPLE_BITS:0] FULL     = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);
  localparam logic [SAMPLE_BITS:0] TWO_FULL = {FULL[SAMPLE_BITS-1:0], 1'b0};
  localparam logic [SB2-1:0]       HALF     = SB2'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [DIV_QW-1:0]    PQ       =
    DIV_QW'((1 << FRAC_SIG) / ((1 << SAMPLE_BITS) - 1));

  logic [DIV_QW-1:0]    quot_r, quot_nxt;
  logic                 done_r;

  logic [SB2-1:0]       rest;
  logic [SAMPLE_BITS:0] fold;
  logic [1:0]           fix;

  assign rest = (SB2'(sample) << RSH) + HALF;
  assign fold = {1'b0, rest[SB2-1:SAMPLE_BITS]} + {1'b0, rest[SAMPLE_BITS-1:0]};

  always_comb begin
    if (fold >= TWO_FULL) begin
      fix = 2'd2;
    end else if (fold >= FULL) begin
      fix = 2'd1;
    end else begin
      fix = 2'd0;
    end
  end

  assign quot_nxt = DIV_QW'(sample) * PQ + DIV_QW'(rest[SB2-1:SAMPLE_BITS]) + DIV_QW'(fix);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hdl/awe_ctrl.sv =====
// Sequencer that walks one sample through scaling, gain, biquad sections and accumulation.
module awe_ctrl #(
  parameter int SECTIONS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  awe_pkg::awe_status_t status,
  output awe_pkg::awe_cmd_t    cmd
);
  import awe_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DIV;
      ST_DIV:    if (status.div_done) state_nxt = ST_LOAD_U;
      ST_LOAD_U: state_nxt = ST_G_LO;
      ST_G_LO:   state_nxt = ST_G_HI;
      ST_G_HI:   state_nxt = ST_G_LD;
      ST_G_LD: begin
        state_nxt = ST_Y;
        sec_nxt   = '0;
      end
      ST_Y:      state_nxt = ST_A1_LO;
      ST_A1_LO:  state_nxt = ST_A1_HI;
      ST_A1_HI:  state_nxt = ST_A2_LO;
      ST_A2_LO:  state_nxt = ST_A2_HI;
      ST_A2_HI:  state_nxt = ST_D1;
      ST_D1: begin
        if (sec_r == SEC_W'(SECTIONS - 1)) begin
          state_nxt = ST_SQ;
        end else begin
          state_nxt = ST_Y;
          sec_nxt   = sec_r + 1'b1;
        end
      end
      ST_SQ:     state_nxt = ST_ACC;
      ST_ACC:    if (!status.out_blocked) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sec  = sec_r;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.div_start = in_valid;
      end
      ST_LOAD_U: cmd.load_u_div = 1'b1;
      ST_G_LO: begin
        cmd.mul_sel = MS_GAIN;
        cmd.mul_op  = MOP_LO;
      end
      ST_G_HI: begin
        cmd.mul_sel = MS_GAIN;
        cmd.mul_op  = MOP_HI;
      end
      ST_G_LD:   cmd.load_u_mul = 1'b1;
      ST_Y:      cmd.calc_y = 1'b1;
      ST_A1_LO: begin
        cmd.mul_sel = MS_A1;
        cmd.mul_op  = MOP_LO;
      end
      ST_A1_HI: begin
        cmd.mul_sel = MS_A1;
        cmd.mul_op  = MOP_HI;
      end
      ST_A2_LO: begin
        cmd.mul_sel = MS_A2;
        cmd.mul_op  = MOP_LO;
        cmd.upd_d0  = 1'b1;
      end
      ST_A2_HI: begin
        cmd.mul_sel = MS_A2;
        cmd.mul_op  = MOP_HI;
      end
      ST_D1: begin
        cmd.upd_d1  = 1'b1;
        cmd.advance = 1'b1;
      end
      ST_SQ:     cmd.square = 1'b1;
      ST_ACC:    cmd.accumulate = !status.out_blocked;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/awe_datapath.sv =====
// Filter registers, shared coefficient multiplier, squarer, energy total and result register.
module awe_datapath #(
  parameter int SECTIONS     = 3,
  parameter int SAMPLE_BITS  = 12,
  parameter int SIGNAL_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  awe_pkg::awe_cmd_t                cmd,
  output awe_pkg::awe_status_t             status,
  input  logic [SAMPLE_BITS-1:0]           in_adc_sample,
  input  logic                             cfg_valid,
  input  logic [awe_pkg::CNT_W-1:0]        cfg_window_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [awe_pkg::ENERGY_W-1:0]     out_energy_sum,
  output logic                             out_sum_saturated
);
  import awe_pkg::*;

  localparam int W   = SIGNAL_WIDTH;
  localparam int EW  = SIGNAL_WIDTH + 4;
  localparam int MQW = SIGNAL_WIDTH + 2;
  localparam int SW  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(W - 1){1'b1}}});
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
    if (v > SAT_HI) return W'(SAT_HI);
    if (v < SAT_LO) return W'(SAT_LO);
    return W'(v);
  endfunction

  logic                   div_done;
  logic [DIV_QW-1:0]      quot;

  logic [CNT_W-1:0]       win_r;
  logic signed [W-1:0]    u_r;
  logic signed [W-1:0]    y_r;
  logic signed [W-1:0]    d0_r [SECTIONS];
  logic signed [W-1:0]    d1_r [SECTIONS];
  logic [MQW-1:0]         mq_r;
  logic                   neg_r;
  logic [ENERGY_W-1:0]    sq_r;
  logic                   sq_big_r;
  logic [ENERGY_W-1:0]    energy_r, energy_nxt;
  logic                   clip_r, clip_nxt;
  logic [CNT_W-1:0]       count_r;
  logic                   out_valid_r;
  logic [ENERGY_W-1:0]    out_energy_r;
  logic                   out_sat_r;

  logic [SW-1:0]          sec_i;
  logic signed [COEF_W-1:0] c_s;
  logic signed [W-1:0]    sig_s;
  logic [COEF_MAGW-1:0]   c_mag;
  logic [W-1:0]           sig_mag;
  logic [MUL_MAGW-1:0]    sig_ext;
  logic [MUL_HALF_W-1:0]  op_b;
  logic [MUL_PROD_W-1:0]  prod;
  logic [MUL_MAGW-1:0]    prod_rnd;

  logic signed [EW-1:0]   u_x, d0_x, d1_x, m_x, b1u_x, b2u_x;
  logic signed [W-1:0]    y_nxt, d0_nxt, d1_nxt;

  logic [W-1:0]           mag_u;
  logic [MUL_MAGW-1:0]    mag_ext;
  logic [ENERGY_W:0]      sum_w;
  logic                   ovf;
  logic [CNT_W:0]         cnt_inc;
  logic [CNT_W:0]         limit;
  logic                   win_end;

  awe_scale_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .sample (in_adc_sample),
    .done   (div_done),
    .quot   (quot)
  );

  assign sec_i = cmd.sec[SW-1:0];

  always_comb begin
    case (cmd.mul_sel)
      MS_GAIN: begin
        c_s   = GAIN_Q22;
        sig_s = u_r;
      end
      MS_A1: begin
        c_s   = a1_coef(cmd.sec);
        sig_s = y_r;
      end
      MS_A2: begin
        c_s   = a2_coef(cmd.sec);
        sig_s = y_r;
      end
      default: begin
        c_s   = GAIN_Q22;
        sig_s = u_r;
      end
    endcase
  end

  assign c_mag    = c_s[COEF_W-1] ? COEF_MAGW'(-c_s) : COEF_MAGW'(c_s);
  assign sig_mag  = sig_s[W-1] ? W'(-sig_s) : W'(sig_s);
  assign sig_ext  = MUL_MAGW'(sig_mag);
  assign op_b     = (cmd.mul_op == MOP_HI) ? sig_ext[MUL_MAGW-1:MUL_HALF_W]
                                           : sig_ext[MUL_HALF_W-1:0];
  assign prod     = c_mag * op_b;
  assign prod_rnd = MUL_MAGW'(prod) + ROUND_HALF;

  assign u_x   = EW'(u_r);
  assign d0_x  = EW'(d0_r[sec_i]);
  assign d1_x  = EW'(d1_r[sec_i]);
  assign m_x   = neg_r ? -EW'(mq_r) : EW'(mq_r);
  assign b1u_x = EW'(b1_coef(cmd.sec)) * u_x;
  assign b2u_x = b2_coef(cmd.sec) ? u_x : '0;

  assign y_nxt  = sat_w(u_x + d0_x);
  assign d0_nxt = sat_w(b1u_x - m_x + d1_x);
  assign d1_nxt = sat_w(b2u_x - m_x);

  assign mag_u   = u_r[W-1] ? W'(-u_r) : W'(u_r);
  assign mag_ext = MUL_MAGW'(mag_u);

  assign sum_w      = {1'b0, energy_r} + {1'b0, sq_r};
  assign ovf        = sq_big_r | sum_w[ENERGY_W];
  assign energy_nxt = ovf ? '1 : sum_w[ENERGY_W-1:0];
  assign clip_nxt   = clip_r | ovf;
  assign cnt_inc    = {1'b0, count_r} + 1'b1;
  assign limit      = (win_r == '0) ? WIN_FULL : {1'b0, win_r};
  assign win_end    = cmd.accumulate && (cnt_inc >= limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (cfg_valid) begin
      win_r <= cfg_window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_u_div) begin
      u_r <= sat_w(EW'(quot));
    end else if (cmd.load_u_mul) begin
      u_r <= sat_w(m_x);
    end else if (cmd.advance) begin
      u_r <= y_r;
    end
    if (cmd.calc_y) begin
      y_r <= y_nxt;
    end
    if (cmd.mul_op == MOP_LO) begin
      mq_r  <= MQW'(prod_rnd[MUL_MAGW-1:FRAC_COEF]);
      neg_r <= c_s[COEF_W-1] ^ sig_s[W-1];
    end else if (cmd.mul_op == MOP_HI) begin
      mq_r <= mq_r + MQW'({prod, 2'b00});
    end
    if (cmd.square) begin
      sq_r     <= mag_ext[SQ_IN_W-1:0] * mag_ext[SQ_IN_W-1:0];
      sq_big_r <= |mag_ext[MUL_MAGW-1:SQ_IN_W];
    end
    if (win_end) begin
      out_energy_r <= energy_nxt;
      out_sat_r    <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        d0_r[i] <= '0;
        d1_r[i] <= '0;
      end
      count_r  <= '0;
      energy_r <= '0;
      clip_r   <= 1'b0;
    end else if (win_end) begin
      for (int i = 0; i < SECTIONS; i++) begin
        d0_r[i] <= '0;
        d1_r[i] <= '0;
      end
      count_r  <= '0;
      energy_r <= '0;
      clip_r   <= 1'b0;
    end else begin
      if (cmd.upd_d0) begin
        d0_r[sec_i] <= d0_nxt;
      end
      if (cmd.upd_d1) begin
        d1_r[sec_i] <= d1_nxt;
      end
      if (cmd.accumulate) begin
        count_r  <= cnt_inc[CNT_W-1:0];
        energy_r <= energy_nxt;
        clip_r   <= clip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (win_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.div_done    = div_done;
  assign status.out_blocked = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_energy_sum    = out_energy_r;
  assign out_sum_saturated = out_sat_r;

endmodule

// ===== bench/energy_window_checker.sv =====
// Watcher for the A-weighted energy accumulator: predicts each window total and compares it.
`timescale 1ns / 1ps
module energy_window_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [11:0]                 in_adc_sample,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [awe_pkg::CNT_W-1:0]   cfg_window_length,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [awe_pkg::ENERGY_W-1:0] out_energy_sum,
  input  logic                        out_sum_saturated,
  output int                          fail_count,
  output int                          windows_due
);

  localparam int CW = awe_pkg::CNT_W;
  localparam longint SIG_MAX = 64'sd2147483647;
  localparam longint SIG_MIN = -64'sd2147483648;
  localparam longint GAIN_WEIGHT = 1072656;
  localparam longint FULL_SCALE = 4095;

  typedef struct packed {
    logic [63:0] energy;
    logic        saturated;
  } window_total_t;

  logic [CW-1:0]  window_len;
  logic [CW-1:0]  samples_in;
  logic [63:0]    energy_acc;
  logic           clip_flag;
  longint         taps [6];
  window_total_t  pending_windows [$];

  function automatic longint clip_signal(input longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Q2.22 coefficient times Q8.24 signal, rounded half away from zero
  function automatic longint weight_q22(input longint coef, input longint sig);
    longint unsigned c, m, q;
    c = magnitude(coef);
    m = magnitude(sig);
    q = ((c * (m >> 24)) << 2) + ((c * (m & 64'hFFFFFF) + (64'd1 << 21)) >> 22);
    return ((coef < 0) != (sig < 0)) ? -longint'(q) : longint'(q);
  endfunction

  task automatic clear_window();
    foreach (taps[k]) taps[k] = 0;
    samples_in = '0;
    energy_acc = '0;
    clip_flag = 1'b0;
  endtask

  task automatic absorb_sample(input logic [11:0] adc);
    longint u, y, b1, a1, a2;
    longint unsigned level, sq, limit;
    logic [CW:0] next_count;
    int s;
    u = clip_signal(((longint'(adc) << 24) + FULL_SCALE / 2) / FULL_SCALE);
    u = clip_signal(weight_q22(GAIN_WEIGHT, u));
    for (s = 0; s < 3; s++) begin
      case (s)
        0: begin
          b1 = 2; a1 = -589451; a2 = 20710;
        end
        1: begin
          b1 = -2; a1 = -7905848; a2 = 3717921;
        end
        default: begin
          b1 = -2; a1 = -8364025; a2 = 4169757;
        end
      endcase
      y = clip_signal(u + taps[2*s]);
      taps[2*s] = clip_signal(b1 * u - weight_q22(a1, y) + taps[2*s+1]);
      taps[2*s+1] = clip_signal(u - weight_q22(a2, y));
      u = y;
    end
    level = magnitude(u);
    if (level >= (64'd1 << 32)) begin
      energy_acc = '1;
      clip_flag = 1'b1;
    end else begin
      sq = level * level;
      if (energy_acc > ~64'd0 - sq) begin
        energy_acc = '1;
        clip_flag = 1'b1;
      end else begin
        energy_acc = energy_acc + sq;
      end
    end
    next_count = samples_in + 1'b1;
    limit = (window_len == 0) ? (64'd1 << CW) : window_len;
    if (next_count >= limit) begin
      pending_windows.push_back({energy_acc, clip_flag});
      clear_window();
    end else begin
      samples_in = next_count[CW-1:0];
    end
  endtask

  always @(posedge clk) begin
    window_total_t due;
    if (!rst_n) begin
      window_len = awe_pkg::WIN_RESET;
      clear_window();
      pending_windows.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          $display("%0t: unexpected window result, expected none, actual %h / %b",
                   $time, out_energy_sum, out_sum_saturated);
          fail_count++;
        end else begin
          due = pending_windows.pop_front();
          if (out_energy_sum !== due.energy) begin
            $display("%0t: energy_sum mismatch, expected %h, actual %h",
                     $time, due.energy, out_energy_sum);
            fail_count++;
          end
          if (out_sum_saturated !== due.saturated) begin
            $display("%0t: sum_saturated mismatch, expected %b, actual %b",
                     $time, due.saturated, out_sum_saturated);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        window_len = cfg_window_length;
      end
      if (in_valid && in_ready) begin
        absorb_sample(in_adc_sample);
      end
    end
    windows_due = pending_windows.size();
  end

endmodule

// ===== bench/a_weighted_energy_accumulator_core_test.sv =====
// Testbench top for the A-weighted energy accumulator: reset, window settings, samples, verdict.
`timescale 1ns / 1ps
module a_weighted_energy_accumulator_core_test;

  localparam int SETTLE_CYCLES = 48;

  typedef enum int {
    TEX_NOISE,
    TEX_RAILS,
    TEX_SQUARE,
    TEX_HUM
  } texture_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [11:0] in_adc_sample = '0;
  logic        cfg_valid = 1'b0;
  logic [19:0] cfg_window_length = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        cfg_ready;
  logic        out_valid;
  logic [63:0] out_energy_sum;
  logic        out_sum_saturated;

  int fail_count;
  int windows_due;
  int send_idle = 37;
  int recv_idle = 76;
  int sent = 0;

  always #1 clk = ~clk;

  a_weighted_energy_accumulator_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy_sum    (out_energy_sum),
    .out_sum_saturated (out_sum_saturated)
  );

  energy_window_checker window_watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_energy_sum    (out_energy_sum),
    .out_sum_saturated (out_sum_saturated),
    .fail_count        (fail_count),
    .windows_due       (windows_due)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic feed(input logic [11:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // drop valid, wait for every pending window, then let the datapath drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (windows_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [19:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_stretch(input int quota);
    int stop_at, w, count, half, i;
    texture_t texture;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 12);
        7, 8: w = $urandom_range(13, 64);
        default: w = $urandom_range(65, 200);
      endcase
      count = (w > 64) ? w : w * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) begin
        count += $urandom_range(0, w - 1);
      end
      if (count > stop_at - sent) begin
        count = stop_at - sent;
      end
      texture = texture_t'($urandom_range(3));
      half = $urandom_range(1, 8);
      set_window(20'(w));
      for (i = 0; i < count; i++) begin
        case (texture)
          TEX_NOISE:  feed(12'($urandom_range(4095)));
          TEX_RAILS:  feed($urandom_range(1) ? 12'hFFF : 12'h000);
          TEX_SQUARE: feed(((i / half) % 2) ? 12'hFFF : 12'h000);
          default:    feed(12'(2016 + $urandom_range(64)));
        endcase
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    settle();
    feed(12'd4095);
    feed(12'd0);
    feed(12'd2048);
    set_window(20'd1);
    feed(12'd0);
    feed(12'd4095);
    feed(12'd4095);
    feed(12'd1);
    feed(12'd4094);
    feed(12'd2048);
    set_window(20'd3);
    feed(12'd4095);
    feed(12'd0);
    feed(12'd4095);
    feed(12'd0);
    feed(12'd4095);
    feed(12'd0);
    set_window(20'd0);
    repeat (5) feed(12'd4095);
    set_window(20'd2);
    feed(12'd0);
    set_window(20'hFFFFF);
    feed(12'd0);
    feed(12'd4095);
    feed(12'd2047);
    set_window(20'd1);
    feed(12'd4095);

    random_stretch(235);
    send_idle = 76;
    recv_idle = 37;
    random_stretch(235);
    send_idle = 0;
    recv_idle = 0;
    random_stretch(235);

    settle();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
